### hw/rtl/s128_pkg.sv
package s128_pkg;

    localparam int WORD_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int Z_W       = 6;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_KEY_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_SECOND = 2'd1;

    // op selector codes
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // key schedule constants: z2 sequence and c = 2^64 - 4
    localparam logic [WORD_W-1:0] Z2_SEQ      = 64'h3369_F885_192C_0EF5;
    localparam logic [WORD_W-1:0] SCHED_CONST = 64'hFFFF_FFFF_FFFF_FFFC;
    localparam logic [Z_W-1:0]    Z_LAST      = 6'd61;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCHED,
        ST_PREP,
        ST_RUN,
        ST_FIN
    } t_state;

    // control from the sequencer to the key store
    typedef struct packed {
        logic start;
        logic rd_en;
    } t_ks_ctrl;

    // status from the key store
    typedef struct packed {
        logic busy;
        logic done;
    } t_ks_stat;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int r);
        return (v << r) | (v >> (WORD_W - r));
    endfunction

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v, input int r);
        return (v >> r) | (v << (WORD_W - r));
    endfunction

    // Simon round function
    function automatic logic [WORD_W-1:0] round_f(input logic [WORD_W-1:0] v);
        return (rotl(v, 1) & rotl(v, 8)) ^ rotl(v, 2);
    endfunction

endpackage

### hw/rtl/s128_key_store.sv
module s128_key_store #(
    parameter int ROUND_COUNT = 68,
    parameter int ADDR_W      = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [s128_pkg::WORD_W-1:0] i_key_first,
    input  logic [s128_pkg::WORD_W-1:0] i_key_second,
    input  s128_pkg::t_ks_ctrl          i_ctrl,
    input  logic [ADDR_W-1:0]           i_rd_addr,
    output s128_pkg::t_ks_stat          o_stat,
    output logic [s128_pkg::WORD_W-1:0] o_rd_data
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ROUND_COUNT - 1);

    logic [s128_pkg::WORD_W-1:0] r_mem [ROUND_COUNT];
    logic [s128_pkg::WORD_W-1:0] r_rd_data;

    logic                        r_busy;
    logic                        r_done;
    logic [ADDR_W-1:0]           r_cnt;
    logic [s128_pkg::Z_W-1:0]    r_z;
    logic [s128_pkg::WORD_W-1:0] r_a;
    logic [s128_pkg::WORD_W-1:0] r_b;
    logic [s128_pkg::WORD_W-1:0] n_b;
    logic [s128_pkg::WORD_W-1:0] w_t;

    // next schedule word from the two newest ones
    always_comb begin
        w_t = s128_pkg::rotr(r_b, 3) ^ s128_pkg::rotr(r_b, 4);
        n_b = r_a ^ w_t ^ s128_pkg::SCHED_CONST
            ^ {{(s128_pkg::WORD_W-1){1'b0}}, s128_pkg::Z2_SEQ[r_z]};
    end

    // schedule sequencer: one round key written per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_z    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_z    <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                r_z   <= (r_z == s128_pkg::Z_LAST) ? '0 : r_z + 1'b1;
                if (r_cnt == LAST_ADDR) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // schedule word pair
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_a <= i_key_first;
            r_b <= i_key_second;
        end else if (r_busy) begin
            r_a <= r_b;
            r_b <= n_b;
        end
    end

    // round key memory, one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_cnt] <= r_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rd_data   = r_rd_data;

endmodule

### hw/rtl/simon128_block_cipher_top.sv
// Channel   Direction  Handshake                       Payload
// config    in         i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data (key words)
// s_axis    in         s_axis_tvalid / s_axis_tready   tdata: block_first, block_second; tuser: op
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata: result_first, result_second
//
// A block passes from acceptance through the prepare state and the rounds to a loaded output register,
// one round per cycle, paced by the single read port of the round key memory.
// The first block after reset or a key write first waits for the key expansion.
// Reset is synchronous, active low; it clears the keys and marks the schedule stale.
// A new block is taken once the previous one has reached the output register;
// a stalled output holds the finished block in the round registers.
module simon128_block_cipher_top #(
    parameter int ROUND_COUNT = 68
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [s128_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [s128_pkg::WORD_W-1:0]          i_cfg_data,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [2*s128_pkg::WORD_W-1:0] s_axis_tdata, // [63:0] block_first, [127:64] block_second
    input  logic                                 s_axis_tuser, // [0] op
    // output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [2*s128_pkg::WORD_W-1:0] m_axis_tdata  // [63:0] result_first, [127:64] result_second
);

    localparam int ADDR_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ROUND_COUNT - 1);

    s128_pkg::t_state   r_state;
    s128_pkg::t_state   n_state;
    s128_pkg::t_ks_ctrl w_ks_ctrl;
    s128_pkg::t_ks_stat w_ks_stat;

    logic [s128_pkg::WORD_W-1:0]   r_key_first;
    logic [s128_pkg::WORD_W-1:0]   r_key_second;
    logic                          r_sched_ok;
    logic                          r_op;
    logic [ADDR_W-1:0]             r_addr;
    logic [ADDR_W-1:0]             r_rnd;
    logic [s128_pkg::WORD_W-1:0]   r_lo;
    logic [s128_pkg::WORD_W-1:0]   r_hi;
    logic [s128_pkg::WORD_W-1:0]   w_rk;
    logic                          r_out_valid;
    logic [2*s128_pkg::WORD_W-1:0] r_out_data;

    logic w_in_acc;
    logic w_cfg_acc;
    logic w_out_free;
    logic w_out_load;
    logic w_last_rnd;
    logic w_step_addr;

    assign w_in_acc   = s_axis_tvalid & s_axis_tready;
    assign w_cfg_acc  = i_cfg_valid & o_cfg_ready;
    assign w_out_free = ~r_out_valid | m_axis_tready;
    assign w_last_rnd = (r_rnd == LAST_ADDR);

    // key registers and schedule status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_first  <= '0;
            r_key_second <= '0;
            r_sched_ok   <= 1'b0;
        end else begin
            if (w_cfg_acc) begin
                unique case (i_cfg_index)
                    s128_pkg::REG_KEY_FIRST: begin
                        r_key_first <= i_cfg_data;
                        r_sched_ok  <= 1'b0;
                    end
                    s128_pkg::REG_KEY_SECOND: begin
                        r_key_second <= i_cfg_data;
                        r_sched_ok   <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end else if (w_ks_stat.done) begin
                r_sched_ok <= 1'b1;
            end
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= s128_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            s128_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = r_sched_ok ? s128_pkg::ST_PREP : s128_pkg::ST_SCHED;
                end
            end
            s128_pkg::ST_SCHED: begin
                if (w_ks_stat.done) begin
                    n_state = s128_pkg::ST_PREP;
                end
            end
            s128_pkg::ST_PREP: begin
                n_state = s128_pkg::ST_RUN;
            end
            s128_pkg::ST_RUN: begin
                if (w_last_rnd) begin
                    n_state = s128_pkg::ST_FIN;
                end
            end
            s128_pkg::ST_FIN: begin
                if (w_out_free) begin
                    n_state = s128_pkg::ST_IDLE;
                end
            end
            default: n_state = s128_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_axis_tready   = 1'b0;
        w_ks_ctrl.start = 1'b0;
        w_ks_ctrl.rd_en = 1'b0;
        w_step_addr     = 1'b0;
        w_out_load      = 1'b0;
        unique case (r_state)
            s128_pkg::ST_IDLE: begin
                s_axis_tready   = 1'b1;
                w_ks_ctrl.start = s_axis_tvalid & ~r_sched_ok;
            end
            s128_pkg::ST_SCHED: begin
            end
            s128_pkg::ST_PREP: begin
                w_ks_ctrl.rd_en = 1'b1;
                w_step_addr     = 1'b1;
            end
            s128_pkg::ST_RUN: begin
                w_ks_ctrl.rd_en = ~w_last_rnd;
                w_step_addr     = ~w_last_rnd;
            end
            s128_pkg::ST_FIN: begin
                w_out_load = w_out_free;
            end
            default: begin
            end
        endcase
    end

    // round counter and key address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd  <= '0;
            r_addr <= '0;
            r_op   <= s128_pkg::OP_ENCRYPT;
        end else begin
            if (w_in_acc) begin
                r_op   <= s_axis_tuser;
                r_addr <= (s_axis_tuser == s128_pkg::OP_DECRYPT) ? LAST_ADDR : '0;
                r_rnd  <= '0;
            end else begin
                if (w_step_addr) begin
                    r_addr <= (r_op == s128_pkg::OP_DECRYPT) ? r_addr - 1'b1 : r_addr + 1'b1;
                end
                if (r_state == s128_pkg::ST_RUN && !w_last_rnd) begin
                    r_rnd <= r_rnd + 1'b1;
                end
            end
        end
    end

    // Feistel round datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_lo <= s_axis_tdata[s128_pkg::WORD_W-1:0];
            r_hi <= s_axis_tdata[2*s128_pkg::WORD_W-1:s128_pkg::WORD_W];
        end else if (r_state == s128_pkg::ST_RUN) begin
            if (r_op == s128_pkg::OP_DECRYPT) begin
                r_hi <= r_lo;
                r_lo <= s128_pkg::round_f(r_lo) ^ r_hi ^ w_rk;
            end else begin
                r_lo <= r_hi;
                r_hi <= s128_pkg::round_f(r_hi) ^ r_lo ^ w_rk;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {r_hi, r_lo};
        end
    end

    s128_key_store #(
        .ROUND_COUNT (ROUND_COUNT),
        .ADDR_W      (ADDR_W)
    ) u_key_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key_first  (r_key_first),
        .i_key_second (r_key_second),
        .i_ctrl       (w_ks_ctrl),
        .i_rd_addr    (r_addr),
        .o_stat       (w_ks_stat),
        .o_rd_data    (w_rk)
    );

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // the key store only writes while the sequencer waits on it
    a_sched_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ks_stat.busy |-> r_state == s128_pkg::ST_SCHED)
        else $error("key schedule running outside the schedule state");

    // a result is loaded only into a free output register
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (!r_out_valid || m_axis_tready))
        else $error("output register overwritten while full");

    // the first round always follows the key read issued in the prepare state
    a_prep_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == s128_pkg::ST_PREP |=> r_state == s128_pkg::ST_RUN && r_rnd == '0)
        else $error("round sequence did not start at round zero");

endmodule

### test/simon128_block_cipher_top_test.sv
module simon128_block_cipher_top_test;

    localparam int ROUNDS      = 68;
    localparam int Z_PERIOD    = 62;
    localparam int DRAIN_WAIT  = 2 * ROUNDS + 16;
    localparam int SETTLE_WAIT = 8;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_SHOWN   = 10;
    localparam int PHASE_ITEMS = 195;
    localparam int HOLD_CYCLES = 600;

    // indexes the block has no register behind
    localparam logic [s128_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [s128_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    // one 128-bit block, first word in the low half
    typedef struct packed {
        logic [s128_pkg::WORD_W-1:0] second;
        logic [s128_pkg::WORD_W-1:0] first;
    } t_block;

    logic                                  i_clk         = 1'b0;
    logic                                  i_rst_n       = 1'b0;
    logic                                  i_cfg_valid   = 1'b0;
    logic                                  o_cfg_ready;
    logic [s128_pkg::CFG_IDX_W-1:0]        i_cfg_index   = '0;
    logic [s128_pkg::WORD_W-1:0]           i_cfg_data    = '0;
    logic                                  s_axis_tvalid = 1'b0;
    logic                                  s_axis_tready;
    logic [2*s128_pkg::WORD_W-1:0]         s_axis_tdata  = '0;
    logic                                  s_axis_tuser  = 1'b0;
    logic                                  m_axis_tvalid;
    logic                                  m_axis_tready = 1'b0;
    logic [2*s128_pkg::WORD_W-1:0]         m_axis_tdata;

    // predictor state: key words and the expanded schedule
    logic [s128_pkg::WORD_W-1:0] key_lo_word = '0;
    logic [s128_pkg::WORD_W-1:0] key_hi_word = '0;
    logic [s128_pkg::WORD_W-1:0] round_keys [ROUNDS];
    bit                          schedule_valid = 1'b0;

    t_block expected_blocks [$];
    int     error_count   = 0;
    int     cycle_count   = 0;
    int     hold_request  = 0;
    bit     sink_stalls   = 1'b0;

    simon128_block_cipher_top #(
        .ROUND_COUNT(ROUNDS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [63:0] block_first, [127:64] block_second
        .s_axis_tuser  (s_axis_tuser),   // [0] op
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [63:0] result_first, [127:64] result_second
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // run-length guard
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [s128_pkg::WORD_W-1:0] spin_left(
        input logic [s128_pkg::WORD_W-1:0] v, input int r);
        return (v << r) | (v >> (s128_pkg::WORD_W - r));
    endfunction

    function automatic logic [s128_pkg::WORD_W-1:0] feistel_mix(
        input logic [s128_pkg::WORD_W-1:0] v);
        return (spin_left(v, 1) & spin_left(v, 8)) ^ spin_left(v, 2);
    endfunction

    // key expansion from the two key words
    function automatic void rebuild_schedule();
        logic [s128_pkg::WORD_W-1:0] t;
        int i;
        round_keys[0] = key_lo_word;
        round_keys[1] = key_hi_word;
        for (i = 2; i < ROUNDS; i++) begin
            t = spin_left(round_keys[i-1], s128_pkg::WORD_W - 3);
            t ^= spin_left(t, s128_pkg::WORD_W - 1);
            round_keys[i] = round_keys[i-2] ^ t ^ s128_pkg::SCHED_CONST
                ^ s128_pkg::WORD_W'(s128_pkg::Z2_SEQ[(i - 2) % Z_PERIOD]);
        end
        schedule_valid = 1'b1;
    endfunction

    // expected cipher output for one block; expands lazily
    function automatic t_block predict_block(input logic op, input t_block blk);
        logic [s128_pkg::WORD_W-1:0] lo, hi, t;
        t_block res;
        int i;
        if (!schedule_valid)
            rebuild_schedule();
        lo = blk.first;
        hi = blk.second;
        if (op == s128_pkg::OP_ENCRYPT) begin
            for (i = 0; i < ROUNDS; i++) begin
                t  = feistel_mix(hi) ^ lo ^ round_keys[i];
                lo = hi;
                hi = t;
            end
        end else begin
            for (i = ROUNDS; i > 0; i--) begin
                t  = feistel_mix(lo) ^ hi ^ round_keys[i-1];
                hi = lo;
                lo = t;
            end
        end
        res.first  = lo;
        res.second = hi;
        return res;
    endfunction

    function automatic logic [s128_pkg::WORD_W-1:0] rand_word();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            2: return 64'h1 << $urandom_range(0, s128_pkg::WORD_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_SHOWN)
            $display("%s", msg);
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_block got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_blocks.size() == 0) begin
                flag_error($sformatf("unexpected result %h_%h", got.second, got.first));
            end else begin
                want = expected_blocks.pop_front();
                if (got.first !== want.first)
                    flag_error($sformatf("result_first: expected %h, got %h",
                                         want.first, got.first));
                if (got.second !== want.second)
                    flag_error($sformatf("result_second: expected %h, got %h",
                                         want.second, got.second));
            end
        end
    end

    // output ready pacing, with a long hold-off on request
    initial begin : sink_pacer
        int   run_left;
        int   hold_left;
        logic level;
        run_left  = 0;
        hold_left = 0;
        level     = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (!sink_stalls) begin
                m_axis_tready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    level    = ~level;
                    run_left = level ? $urandom_range(1, 20) : $urandom_range(1, 10);
                end
                run_left--;
                m_axis_tready <= level;
            end
        end
    end

    // one input transaction; prediction taken at acceptance
    task automatic send_block(input logic op, input logic [s128_pkg::WORD_W-1:0] first,
                              input logic [s128_pkg::WORD_W-1:0] second);
        t_block blk;
        blk.first  = first;
        blk.second = second;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= blk;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        expected_blocks.push_back(predict_block(op, blk));
    endtask

    task automatic pause_source(input int n);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // stop the source and let every outstanding block come out
    task automatic quiesce();
        pause_source(1);
        while (expected_blocks.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    // one configuration transaction
    task automatic write_reg(input logic [s128_pkg::CFG_IDX_W-1:0] idx,
                             input logic [s128_pkg::WORD_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            s128_pkg::REG_KEY_FIRST: begin
                key_lo_word    = value;
                schedule_valid = 1'b0;
            end
            s128_pkg::REG_KEY_SECOND: begin
                key_hi_word    = value;
                schedule_valid = 1'b0;
            end
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_keys(input logic [s128_pkg::WORD_W-1:0] k_first,
                             input logic [s128_pkg::WORD_W-1:0] k_second);
        quiesce();
        write_reg(s128_pkg::REG_KEY_FIRST, k_first);
        write_reg(s128_pkg::REG_KEY_SECOND, k_second);
    endtask

    // keys straight out of reset, schedule built on first block
    task automatic test_reset_keys();
        sink_stalls = 1'b0;
        send_block(s128_pkg::OP_ENCRYPT, '0, '0);
        send_block(s128_pkg::OP_DECRYPT, '0, '0);
        send_block(s128_pkg::OP_ENCRYPT, '1, '1);
    endtask

    // published key and plaintext, then the round trip of its ciphertext and a decrypt of the plaintext
    task automatic test_standard_vector();
        t_block ct;
        load_keys(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908);
        send_block(s128_pkg::OP_ENCRYPT, 64'h6c6c_6576_6172_7420, 64'h6373_6564_2073_7265);
        ct = expected_blocks[$];
        send_block(s128_pkg::OP_DECRYPT, ct.first, ct.second);
        send_block(s128_pkg::OP_DECRYPT, 64'h6c6c_6576_6172_7420, 64'h6373_6564_2073_7265);
    endtask

    // extreme keys and blocks, both directions
    task automatic test_extremes();
        load_keys('1, '1);
        send_block(s128_pkg::OP_ENCRYPT, '0, '0);
        send_block(s128_pkg::OP_DECRYPT, '0, '0);
        send_block(s128_pkg::OP_ENCRYPT, '1, '1);
        send_block(s128_pkg::OP_DECRYPT, '1, '1);
        load_keys('0, '1);
        send_block(s128_pkg::OP_ENCRYPT, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        send_block(s128_pkg::OP_DECRYPT, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        load_keys('1, '0);
        send_block(s128_pkg::OP_ENCRYPT, '1, '0);
        send_block(s128_pkg::OP_DECRYPT, '0, '1);
    endtask

    // single key word rewritten between blocks
    task automatic test_key_update();
        quiesce();
        write_reg(s128_pkg::REG_KEY_FIRST, rand_word());
        send_block(s128_pkg::OP_ENCRYPT, rand_word(), rand_word());
        quiesce();
        write_reg(s128_pkg::REG_KEY_SECOND, rand_word());
        send_block(s128_pkg::OP_DECRYPT, rand_word(), rand_word());
        quiesce();
        write_reg(s128_pkg::REG_KEY_FIRST, rand_word());
        write_reg(s128_pkg::REG_KEY_FIRST, rand_word());
        send_block(s128_pkg::OP_ENCRYPT, rand_word(), rand_word());
    endtask

    // writes to unused indexes leave the keys alone
    task automatic test_spare_index();
        quiesce();
        write_reg(REG_SPARE_LO, rand_word());
        write_reg(REG_SPARE_HI, rand_word());
        send_block(s128_pkg::OP_ENCRYPT, rand_word(), rand_word());
        send_block(s128_pkg::OP_DECRYPT, rand_word(), rand_word());
    endtask

    // output held off long enough that the input has to stall
    task automatic test_backpressure();
        int n;
        quiesce();
        sink_stalls  = 1'b1;
        hold_request = HOLD_CYCLES;
        for (n = 0; n < 12; n++)
            send_block(logic'($urandom_range(0, 1)), rand_word(), rand_word());
    endtask

    // random blocks in bursts with random gaps
    task automatic random_burst_traffic(input int count, input int gap_max);
        int burst_left;
        int n;
        burst_left = 0;
        for (n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                if (gap_max > 0)
                    pause_source($urandom_range(1, gap_max));
                burst_left = $urandom_range(1, 24);
            end
            send_block(logic'($urandom_range(0, 1)), rand_word(), rand_word());
            burst_left--;
        end
    endtask

    // six key settings; phases 1 and 4 run without output stalls or input gaps
    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                1: load_keys('0, '0);
                2: load_keys('1, '1);
                4: begin
                    quiesce();
                    write_reg(s128_pkg::REG_KEY_FIRST, rand_word());
                end
                default: load_keys(rand_word(), rand_word());
            endcase
            sink_stalls = (phase % 3) != 1;
            random_burst_traffic(PHASE_ITEMS, (phase % 3 == 1) ? 0 : 90);
        end
    endtask

    // test sequence
    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_keys();
        test_standard_vector();
        test_extremes();
        test_key_update();
        test_spare_index();
        test_backpressure();
        test_random_traffic();
        quiesce();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
